/* rtl/rrta_pkg.sv */
package rrta_pkg;

  // Request kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_MARK  = 2'd1;
  localparam logic [1:0] KIND_ALLOC = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_NOTFREE = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  // One table entry as stored in the region memory
  typedef struct packed {
    logic        taken;
    logic [32:0] size;
    logic [31:0] start;
  } entry_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_START,
    OP_SCAN_RD,
    OP_SCAN_EV,
    OP_FIT_TO_MARK,
    OP_REB_START,
    OP_REB_RD,
    OP_REB_EV,
    OP_FLUSH,
    OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       res_valid;
    logic [2:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       is_query;
    logic       is_fit;
    logic       range_bad;
    logic       len_zero;
    logic       scan_done;
    logic       found;
    logic       hit_taken;
    logic       old_avail;
    logic       piece_avail;
    logic       ev_old;
    logic       full;
  } stat_t;

endpackage

/* rtl/rrta_ctrl.sv */
module rrta_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rrta_pkg::stat_t st,
  output rrta_pkg::cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_CHECK     = 10'b0000000010,
    S_SCAN_RD   = 10'b0000000100,
    S_SCAN_EV   = 10'b0000001000,
    S_REB_START = 10'b0000010000,
    S_REB_RD    = 10'b0000100000,
    S_REB_EV    = 10'b0001000000,
    S_FLUSH     = 10'b0010000000,
    S_COMMIT    = 10'b0100000000,
    S_DONE      = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and datapath command
  always_comb begin
    state_next     = state;
    cmd.op         = rrta_pkg::OP_NONE;
    cmd.res_valid  = 1'b0;
    cmd.res_status = rrta_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = rrta_pkg::OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.kind == rrta_pkg::KIND_ADD) begin
          if (st.range_bad) begin
            cmd.res_valid  = 1'b1;
            cmd.res_status = rrta_pkg::ST_RANGE;
            state_next     = S_DONE;
          end else if (st.len_zero) begin
            cmd.res_valid  = 1'b1;
            cmd.res_status = rrta_pkg::ST_OK;
            state_next     = S_DONE;
          end else begin
            state_next = S_REB_START;
          end
        end else if (st.kind == rrta_pkg::KIND_MARK && st.range_bad) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = rrta_pkg::ST_RANGE;
          state_next     = S_DONE;
        end else begin
          cmd.op     = rrta_pkg::OP_SCAN_START;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (!st.scan_done) begin
          cmd.op     = rrta_pkg::OP_SCAN_RD;
          state_next = S_SCAN_EV;
        end else if (st.is_query) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = st.found ? rrta_pkg::ST_OK : rrta_pkg::ST_RANGE;
          state_next     = S_DONE;
        end else if (st.is_fit) begin
          if (st.found) begin
            cmd.op     = rrta_pkg::OP_FIT_TO_MARK;
            state_next = S_SCAN_RD;
          end else begin
            cmd.res_valid  = 1'b1;
            cmd.res_status = rrta_pkg::ST_NOFIT;
            state_next     = S_DONE;
          end
        end else if (st.found && !st.hit_taken) begin
          state_next = S_REB_START;
        end else begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = rrta_pkg::ST_NOTFREE;
          state_next     = S_DONE;
        end
      end
      S_SCAN_EV: begin
        cmd.op     = rrta_pkg::OP_SCAN_EV;
        state_next = S_SCAN_RD;
      end
      S_REB_START: begin
        cmd.op     = rrta_pkg::OP_REB_START;
        state_next = S_REB_RD;
      end
      S_REB_RD: begin
        if (st.old_avail) begin
          cmd.op     = rrta_pkg::OP_REB_RD;
          state_next = S_REB_EV;
        end else if (st.piece_avail) begin
          state_next = S_REB_EV;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_REB_EV: begin
        cmd.op     = rrta_pkg::OP_REB_EV;
        state_next = (st.ev_old || !st.old_avail) ? S_REB_RD : S_REB_EV;
      end
      S_FLUSH: begin
        cmd.op     = rrta_pkg::OP_FLUSH;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.res_valid = 1'b1;
        if (st.full) begin
          cmd.res_status = rrta_pkg::ST_FULL;
        end else begin
          cmd.op = rrta_pkg::OP_COMMIT;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

endmodule

/* rtl/rrta_dp.sv */
module rrta_dp #(
  parameter int MAX_REGIONS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      kind,
  input  logic [31:0]     start_addr,
  input  logic [31:0]     length_bytes,
  input  rrta_pkg::cmd_t  cmd,
  output rrta_pkg::stat_t st,
  output logic [31:0]     result_addr,
  output logic [2:0]      status
);

  localparam int CW    = $clog2(MAX_REGIONS + 1);
  localparam int IW    = $clog2(MAX_REGIONS);
  localparam int OCW   = $clog2(MAX_REGIONS + 4);
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 ** AW;

  // Two banks: one holds the live table, the other takes the rebuilt one
  rrta_pkg::entry_t mem [DEPTH];
  rrta_pkg::entry_t rdata;

  logic [1:0]       kind_r;
  logic [31:0]      s_r;
  logic [31:0]      len_r;
  logic             phase;
  logic [CW-1:0]    count;
  logic             bank;
  logic [CW-1:0]    idx;
  logic             found;
  logic [CW-1:0]    hit_idx;
  rrta_pkg::entry_t hit;
  rrta_pkg::entry_t piece [3];
  logic [2:0]       pvalid;
  logic             rebuild_mark;
  rrta_pkg::entry_t pend;
  logic             pv;
  logic [OCW-1:0]   ocount;

  logic             mark_mode, fit_mode, query_mode;
  logic [32:0]      end_r, end_req;
  logic             c_contain, c_fit, c_best, hit_now;
  logic [1:0]       psel;
  rrta_pkg::entry_t pcur, e;
  logic             old_avail, skip, ev_old, emit_v, merge_ok;
  logic             re, we;
  logic [AW-1:0]    raddr, waddr;
  logic [31:0]      off;

  assign mark_mode  = (kind_r == rrta_pkg::KIND_MARK) ||
                      (kind_r == rrta_pkg::KIND_ALLOC && phase);
  assign fit_mode   = (kind_r == rrta_pkg::KIND_ALLOC) && !phase;
  assign query_mode = (kind_r == rrta_pkg::KIND_QUERY);

  // Evaluate the entry just read against the current scan
  assign end_r     = {1'b0, rdata.start} + rdata.size;
  assign end_req   = {1'b0, s_r} + {1'b0, len_r};
  assign c_contain = (rdata.start <= s_r) && (end_r >= end_req);
  assign c_fit     = !rdata.taken && (rdata.size >= {1'b0, len_r});
  assign c_best    = !rdata.taken && (!found || rdata.size > hit.size);
  assign hit_now   = mark_mode ? c_contain : (fit_mode ? c_fit : c_best);

  // Pick the earliest pending piece
  always_comb begin
    if (pvalid[0]) begin
      psel = 2'd0;
    end else if (pvalid[1]) begin
      psel = 2'd1;
    end else begin
      psel = 2'd2;
    end
  end
  assign pcur = piece[psel];

  assign old_avail = (idx < count);
  assign skip      = rebuild_mark && (idx == hit_idx);
  assign ev_old    = old_avail && (skip || !(|pvalid) || rdata.start <= pcur.start);
  assign e         = ev_old ? rdata : pcur;
  assign emit_v    = (cmd.op == rrta_pkg::OP_REB_EV) && !(old_avail && skip);
  assign merge_ok  = pv && (pend.taken == e.taken) &&
                     (({1'b0, pend.start} + pend.size) == {1'b0, e.start});
  assign off       = s_r - hit.start;

  // Region memory ports
  assign re    = (cmd.op == rrta_pkg::OP_SCAN_RD) || (cmd.op == rrta_pkg::OP_REB_RD);
  assign raddr = {bank, idx[IW-1:0]};
  assign waddr = {~bank, ocount[IW-1:0]};
  assign we    = pv && (ocount < OCW'(MAX_REGIONS)) &&
                 ((emit_v && !merge_ok) || cmd.op == rrta_pkg::OP_FLUSH);

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= pend;
    end
  end

  // Table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      bank  <= 1'b0;
    end else if (cmd.op == rrta_pkg::OP_COMMIT) begin
      count <= ocount[CW-1:0];
      bank  <= ~bank;
    end
  end

  // Request, scan and rebuild registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      rrta_pkg::OP_LOAD: begin
        kind_r <= kind;
        s_r    <= start_addr;
        len_r  <= length_bytes;
        phase  <= 1'b0;
      end
      rrta_pkg::OP_SCAN_START: begin
        idx   <= '0;
        found <= 1'b0;
      end
      rrta_pkg::OP_SCAN_EV: begin
        if (hit_now) begin
          found   <= 1'b1;
          hit_idx <= idx;
          hit     <= rdata;
        end
        idx <= idx + 1'b1;
      end
      rrta_pkg::OP_FIT_TO_MARK: begin
        s_r   <= hit.start;
        phase <= 1'b1;
        idx   <= '0;
        found <= 1'b0;
      end
      rrta_pkg::OP_REB_START: begin
        idx          <= '0;
        pv           <= 1'b0;
        ocount       <= '0;
        rebuild_mark <= (kind_r != rrta_pkg::KIND_ADD);
        if (kind_r == rrta_pkg::KIND_ADD) begin
          piece[0] <= '{taken: 1'b0, size: {1'b0, len_r}, start: s_r};
          piece[1] <= '{taken: 1'b0, size: '0, start: s_r};
          piece[2] <= '{taken: 1'b0, size: '0, start: s_r};
          pvalid   <= 3'b001;
        end else begin
          piece[0] <= '{taken: 1'b0, size: {1'b0, off}, start: hit.start};
          piece[1] <= '{taken: 1'b1, size: {1'b0, len_r}, start: s_r};
          piece[2] <= '{taken: 1'b0,
                        size: hit.size - {1'b0, len_r} - {1'b0, off},
                        start: s_r + len_r};
          pvalid   <= {(hit.size - {1'b0, len_r} - {1'b0, off}) != '0,
                       len_r != '0, off != '0};
        end
      end
      rrta_pkg::OP_REB_EV: begin
        if (ev_old) begin
          idx <= idx + 1'b1;
        end else begin
          pvalid[psel] <= 1'b0;
        end
        if (emit_v) begin
          if (merge_ok) begin
            pend.size <= pend.size + e.size;
          end else begin
            if (pv) begin
              ocount <= ocount + 1'b1;
            end
            pend <= e;
            pv   <= 1'b1;
          end
        end
      end
      rrta_pkg::OP_FLUSH: begin
        if (pv) begin
          ocount <= ocount + 1'b1;
        end
        pv <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Latch the result beat
  always_ff @(posedge clk) begin
    if (cmd.res_valid) begin
      status <= cmd.res_status;
      if (cmd.res_status != rrta_pkg::ST_OK) begin
        result_addr <= '0;
      end else if (kind_r == rrta_pkg::KIND_ALLOC) begin
        result_addr <= s_r;
      end else if (kind_r == rrta_pkg::KIND_QUERY) begin
        result_addr <= hit.start;
      end else begin
        result_addr <= '0;
      end
    end
  end

  assign st.kind        = kind_r;
  assign st.is_query    = query_mode;
  assign st.is_fit      = fit_mode;
  assign st.range_bad   = end_req > 33'h1_0000_0000;
  assign st.len_zero    = (len_r == '0);
  assign st.scan_done   = (idx == count) || (found && !query_mode);
  assign st.found       = found;
  assign st.hit_taken   = hit.taken;
  assign st.old_avail   = old_avail;
  assign st.piece_avail = |pvalid;
  assign st.ev_old      = ev_old;
  assign st.full        = ocount > OCW'(MAX_REGIONS);

endmodule

/* rtl/ram_region_table_allocator.sv */
// Channel | Signals                               | Dir | Beat taken when
// input   | kind, start_addr, length_bytes         | in  | in_valid & in_ready
// output  | result_addr, status                    | out | out_valid & out_ready
//
// One request in flight; its single result beat holds while out_ready is low.
// Scans and rebuilds into the spare bank read, then evaluate, each entry in turn.
// A query scans the table, an add rebuilds it, a mark scans and then rebuilds, and
// an allocate makes two scans, then a rebuild.
// Reset (synchronous, active high) empties the table by clearing its count; no sweep.
// in_ready drops from acceptance until the result beat is taken.
module ram_region_table_allocator #(
  parameter int MAX_REGIONS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] start_addr,
  input  logic [31:0] length_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_addr,
  output logic [2:0]  status
);

  rrta_pkg::cmd_t  cmd;
  rrta_pkg::stat_t st;

  rrta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  rrta_dp #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .kind         (kind),
    .start_addr   (start_addr),
    .length_bytes (length_bytes),
    .cmd          (cmd),
    .st           (st),
    .result_addr  (result_addr),
    .status       (status)
  );

endmodule

/* rtl/rrta_checker.sv */
module rrta_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_addr,
  input logic [2:0]  status
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_addr) && $stable(status))
    else $error("result beat changed while stalled");

  // Never take a request while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // Drop ready after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  // Failed requests report address zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != rrta_pkg::ST_OK |-> result_addr == 32'd0)
    else $error("nonzero address on failure");

  // Keep status within defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= rrta_pkg::ST_RANGE)
    else $error("undefined status code");

endmodule

bind ram_region_table_allocator rrta_checker u_rrta_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_addr (result_addr),
  .status      (status)
);

/* sim/region_table_checker.sv */
module region_table_checker #(
  parameter int MAX_REGIONS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] start_addr,
  input  logic [31:0] length_bytes,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] result_addr,
  input  logic [2:0]  status,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR = MAX_REGIONS + 3;

  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  st;
  } answer_t;

  // committed table
  logic [31:0] tbl_start [MAX_REGIONS];
  logic [32:0] tbl_size  [MAX_REGIONS];
  logic        tbl_taken [MAX_REGIONS];
  int          tbl_count;

  // scratch table for building changes
  logic [31:0] scr_start [SCR];
  logic [32:0] scr_size  [SCR];
  logic        scr_taken [SCR];
  int          scr_count;

  answer_t answers_due[$];

  assign pending_count = answers_due.size();

  function automatic void scr_load();
    scr_count = tbl_count;
    for (int i = 0; i < tbl_count; i++) begin
      scr_start[i] = tbl_start[i];
      scr_size[i]  = tbl_size[i];
      scr_taken[i] = tbl_taken[i];
    end
  endfunction

  function automatic void scr_push(logic [32:0] s, logic [32:0] z, logic t);
    if (z == 0 || scr_count >= SCR) return;
    scr_start[scr_count] = s[31:0];
    scr_size[scr_count]  = z;
    scr_taken[scr_count] = t;
    scr_count++;
  endfunction

  function automatic void scr_drop(int idx);
    for (int i = idx; i + 1 < scr_count; i++) begin
      scr_start[i] = scr_start[i+1];
      scr_size[i]  = scr_size[i+1];
      scr_taken[i] = scr_taken[i+1];
    end
    scr_count--;
  endfunction

  // sort stable by start, merge touching same-mark pieces, then commit if it fits
  function automatic logic [2:0] scr_commit();
    logic [31:0] s;
    logic [32:0] z;
    logic        t;
    int          j;
    int          i;
    for (i = 1; i < scr_count; i++) begin
      s = scr_start[i]; z = scr_size[i]; t = scr_taken[i];
      j = i;
      while (j > 0 && scr_start[j-1] > s) begin
        scr_start[j] = scr_start[j-1];
        scr_size[j]  = scr_size[j-1];
        scr_taken[j] = scr_taken[j-1];
        j--;
      end
      scr_start[j] = s; scr_size[j] = z; scr_taken[j] = t;
    end
    i = 1;
    while (i < scr_count) begin
      if (scr_taken[i-1] == scr_taken[i] &&
          {1'b0, scr_start[i-1]} + scr_size[i-1] == {1'b0, scr_start[i]}) begin
        scr_size[i-1] += scr_size[i];
        scr_drop(i);
      end else begin
        i++;
      end
    end
    if (scr_count > MAX_REGIONS) return rrta_pkg::ST_FULL;
    for (i = 0; i < scr_count; i++) begin
      tbl_start[i] = scr_start[i];
      tbl_size[i]  = scr_size[i];
      tbl_taken[i] = scr_taken[i];
    end
    tbl_count = scr_count;
    return rrta_pkg::ST_OK;
  endfunction

  function automatic logic [2:0] mark_range(logic [32:0] s, logic [32:0] len);
    int          hit;
    logic [32:0] rs, rz;
    if (s + len > 33'h1_0000_0000) return rrta_pkg::ST_RANGE;
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if ({1'b0, tbl_start[i]} <= s && {1'b0, tbl_start[i]} + tbl_size[i] >= s + len) begin
        hit = i;
        break;
      end
    end
    if (hit < 0) return rrta_pkg::ST_NOTFREE;
    if (tbl_taken[hit]) return rrta_pkg::ST_NOTFREE;
    rs = {1'b0, tbl_start[hit]};
    rz = tbl_size[hit];
    scr_load();
    scr_drop(hit);
    scr_push(rs, s - rs, 1'b0);
    scr_push(s, len, 1'b1);
    scr_push(s + len, rz - len - (s - rs), 1'b0);
    return scr_commit();
  endfunction

  function automatic answer_t serve_request(logic [1:0] k, logic [31:0] sa, logic [31:0] ln);
    answer_t     a;
    logic [32:0] s, len;
    int          best;
    s = {1'b0, sa};
    len = {1'b0, ln};
    a.addr = '0;
    a.st = rrta_pkg::ST_OK;
    case (k)
      rrta_pkg::KIND_ADD: begin
        if (s + len > 33'h1_0000_0000) a.st = rrta_pkg::ST_RANGE;
        else if (len != 0) begin
          scr_load();
          scr_push(s, len, 1'b0);
          a.st = scr_commit();
        end
      end
      rrta_pkg::KIND_MARK: a.st = mark_range(s, len);
      rrta_pkg::KIND_ALLOC: begin
        best = -1;
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_taken[i] && tbl_size[i] >= len) begin
            best = i;
            break;
          end
        end
        if (best < 0) a.st = rrta_pkg::ST_NOFIT;
        else begin
          a.addr = tbl_start[best];
          a.st = mark_range({1'b0, tbl_start[best]}, len);
          if (a.st != rrta_pkg::ST_OK) a.addr = '0;
        end
      end
      default: begin
        best = -1;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_taken[i]) continue;
          if (best < 0 || tbl_size[i] > tbl_size[best]) best = i;
        end
        if (best >= 0) a.addr = tbl_start[best];
        else a.st = rrta_pkg::ST_RANGE;
      end
    endcase
    return a;
  endfunction

  // predict on each request beat, compare on each result beat
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      tbl_count = 0;
      answers_due.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) answers_due.push_back(serve_request(kind, start_addr, length_bytes));
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result beat addr=%h status=%0d", $time, result_addr, status);
          fail_count <= fail_count + 1;
        end else begin
          want = answers_due.pop_front();
          if (want.addr !== result_addr || want.st !== status) begin
            $display("%0t: mismatch expected addr=%h status=%0d, actual addr=%h status=%0d",
                     $time, want.addr, want.st, result_addr, status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [31:0] start_addr;
  logic [31:0] length_bytes;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] result_addr;
  logic [2:0]  status;
  int          fail_count;
  int          pending_count;
  bit          quiet_phase;

  ram_region_table_allocator #(.MAX_REGIONS(64)) DUT (.*);

  region_table_checker #(.MAX_REGIONS(64)) checker_inst (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int gap_len();
    if (quiet_phase) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
    return 0;
  endfunction

  // random result-side backpressure
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      n = gap_len();
      out_ready <= (n == 0);
      repeat (n + 1) @(posedge clk);
    end
  end

  // present one request beat and hold it until taken
  task automatic send_beat(logic [1:0] k, logic [31:0] sa, logic [31:0] ln);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    start_addr <= sa;
    length_bytes <= ln;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // mostly small addresses so regions touch and merge, sometimes full range
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 64);
      default: return $urandom_range(0, 255) * 16;
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 0;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 16) * 16;
    endcase
  endfunction

  initial begin
    logic [31:0] a, l;
    in_valid <= 1'b0;
    kind <= rrta_pkg::KIND_ADD;
    start_addr <= '0;
    length_bytes <= '0;
    quiet_phase = 0;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty queries, range errors, zero lengths, extremes, split cases
    send_beat(rrta_pkg::KIND_QUERY, 0, 0);
    send_beat(rrta_pkg::KIND_ALLOC, 0, 1);
    send_beat(rrta_pkg::KIND_MARK, 32'h10, 4);
    send_beat(rrta_pkg::KIND_ADD, 32'hFFFF_FFFF, 2);
    send_beat(rrta_pkg::KIND_ADD, 32'h100, 0);
    send_beat(rrta_pkg::KIND_ADD, 32'hFFFF_FFFF, 1);
    send_beat(rrta_pkg::KIND_ADD, 32'h1000, 32'h1000);
    send_beat(rrta_pkg::KIND_ADD, 32'h2000, 32'h800);
    send_beat(rrta_pkg::KIND_ADD, 32'h1800, 32'h1000);
    send_beat(rrta_pkg::KIND_MARK, 32'h1400, 0);
    send_beat(rrta_pkg::KIND_MARK, 32'h1400, 32'h100);
    send_beat(rrta_pkg::KIND_MARK, 32'h1400, 32'h10);
    send_beat(rrta_pkg::KIND_MARK, 32'h1000, 32'h100);
    send_beat(rrta_pkg::KIND_MARK, 32'h2700, 32'h100);
    send_beat(rrta_pkg::KIND_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(rrta_pkg::KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(rrta_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'h200);
    send_beat(rrta_pkg::KIND_ALLOC, 0, 32'hFFFF_FFFF);
    send_beat(rrta_pkg::KIND_ALLOC, 0, 0);
    send_beat(rrta_pkg::KIND_ADD, 0, 32'hFFFF_FFFF);
    send_beat(rrta_pkg::KIND_QUERY, 0, 0);
    send_beat(rrta_pkg::KIND_ALLOC, 0, 32'h8000_0000);
    send_beat(rrta_pkg::KIND_QUERY, 0, 0);

    // fill the table with disjoint pieces to hit the full status
    for (int i = 0; i < 70; i++) send_beat(rrta_pkg::KIND_ADD, 32'h4000_0000 + i * 32, 16);
    send_beat(rrta_pkg::KIND_MARK, 32'h4000_0004, 4);

    // random traffic with an unthrottled stretch in the middle
    for (int i = 0; i < 1760; i++) begin
      quiet_phase = (i >= 700 && i < 900);
      a = pick_addr();
      l = pick_len();
      if ($urandom_range(0, 3) == 0 && {1'b0, a} + {1'b0, l} > 33'h1_0000_0000)
        l = 32'hFFFF_FFFF - a + 1;
      send_beat(2'($urandom_range(0, 3)), a, l);
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
